// File: src/lort_pkg.sv
package lort_pkg;

	localparam int KEY_SPACE  = 1024;
	localparam int COUNT_BITS = 16;
	localparam int KEY_BITS   = $clog2(KEY_SPACE);
	localparam int LEN_BITS   = $clog2(KEY_SPACE + 1);
	localparam int HIST_DEPTH = KEY_SPACE + 1;
	localparam int HIST_BITS  = LEN_BITS;

	localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
	localparam logic [KEY_BITS-1:0]   KEY_LAST = KEY_BITS'(KEY_SPACE - 1);
	localparam logic [LEN_BITS-1:0]   CLR_LAST = LEN_BITS'(KEY_SPACE);

	typedef enum logic [21:0] {
		S_CLR    = 22'd1 << 0,
		S_IDLE   = 22'd1 << 1,
		S_CNT    = 22'd1 << 2,
		S_RREQ   = 22'd1 << 3,
		S_RRSP   = 22'd1 << 4,
		S_LREQ   = 22'd1 << 5,
		S_LRSP   = 22'd1 << 6,
		S_ADDINS = 22'd1 << 7,
		S_SLREQ  = 22'd1 << 8,
		S_SLRSP  = 22'd1 << 9,
		S_SRREQ  = 22'd1 << 10,
		S_SRRSP  = 22'd1 << 11,
		S_SPLIT  = 22'd1 << 12,
		S_SPL_L  = 22'd1 << 13,
		S_SPL_R  = 22'd1 << 14,
		S_HRD    = 22'd1 << 15,
		S_HWR    = 22'd1 << 16,
		S_PW1    = 22'd1 << 17,
		S_PW2    = 22'd1 << 18,
		S_FIXREQ = 22'd1 << 19,
		S_FIXRSP = 22'd1 << 20,
		S_OUT    = 22'd1 << 21
	} state_t;

endpackage

// File: src/lort_ram.sv
module lort_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int ABITS = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/longest_occupied_run_tracker.sv
// Tracks a count per key and the longest run of adjacent keys with nonzero count. After reset
// the block clears its count and histogram memories with busy high. A beat is taken when
// start is high and busy is low, and exactly one result follows, marked by done for a
// single cycle; the receiver cannot stall it and must take it then. A request that leaves the
// set of occupied keys unchanged goes from the count update straight to the result. An add
// that makes a key occupied takes longer, depending on whether the key has neighbors that are
// occupied. A removal that empties a key walks the count memory one key at a time to both ends
// of its run, so its cost grows with that run's length, plus the insert and search steps.
module longest_occupied_run_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [lort_pkg::KEY_BITS-1:0]       key,
	input  logic                                req_type,
	output logic                                done,
	output logic [lort_pkg::LEN_BITS-1:0]       longest_run,
	output logic [lort_pkg::COUNT_BITS-1:0]     key_count,
	output logic                                rejected
);

	localparam int KB = lort_pkg::KEY_BITS;
	localparam int LB = lort_pkg::LEN_BITS;
	localparam int CB = lort_pkg::COUNT_BITS;

	lort_pkg::state_t state_q, state_d, hret_q, hret_d, iret_q, iret_d;
	logic [LB-1:0] clr_q, clr_d, longest_q, longest_d, haddr_q, haddr_d;
	logic [KB-1:0] key_q, key_d, lo_q, lo_d, hi_q, hi_d, ilo_q, ilo_d, ihi_q, ihi_d;
	logic          rm_q, rm_d, rej_q, rej_d, hinc_q, hinc_d;
	logic [CB-1:0] kcnt_q, kcnt_d;

	logic          c_we;
	logic [KB-1:0] c_waddr, c_raddr;
	logic [CB-1:0] c_wdata, c_rdata;
	logic          p_we;
	logic [KB-1:0] p_waddr, p_raddr, p_wdata, p_rdata;
	logic          h_we;
	logic [LB-1:0] h_waddr, h_raddr;
	logic [lort_pkg::HIST_BITS-1:0] h_wdata, h_rdata;

	logic [KB-1:0] pr;
	logic [LB-1:0] ins_len;

	lort_ram #(.DEPTH(lort_pkg::KEY_SPACE), .WIDTH(CB)) u_counts (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	lort_ram #(.DEPTH(lort_pkg::KEY_SPACE), .WIDTH(KB)) u_partner (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	lort_ram #(.DEPTH(lort_pkg::HIST_DEPTH), .WIDTH(lort_pkg::HIST_BITS)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	assign ins_len = {1'b0, ihi_q} - {1'b0, ilo_q} + LB'(1);

	always_comb begin
		state_d   = state_q;
		hret_d    = hret_q;
		iret_d    = iret_q;
		clr_d     = clr_q;
		longest_d = longest_q;
		haddr_d   = haddr_q;
		key_d     = key_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		ilo_d     = ilo_q;
		ihi_d     = ihi_q;
		rm_d      = rm_q;
		rej_d     = rej_q;
		hinc_d    = hinc_q;
		kcnt_d    = kcnt_q;
		c_we      = 1'b0;
		c_waddr   = key_q;
		c_wdata   = '0;
		c_raddr   = key_q;
		p_we      = 1'b0;
		p_waddr   = ilo_q;
		p_wdata   = ihi_q;
		p_raddr   = key_q;
		h_we      = 1'b0;
		h_waddr   = haddr_q;
		h_wdata   = '0;
		h_raddr   = haddr_q;
		pr        = p_rdata;
		unique case (state_q)
			lort_pkg::S_CLR: begin
				c_we    = (clr_q < lort_pkg::CLR_LAST);
				c_waddr = clr_q[KB-1:0];
				h_we    = 1'b1;
				h_waddr = clr_q;
				if (clr_q == lort_pkg::CLR_LAST) begin
					state_d = lort_pkg::S_IDLE;
				end else begin
					clr_d = clr_q + LB'(1);
				end
			end
			lort_pkg::S_IDLE: begin
				c_raddr = key;
				if (start) begin
					key_d   = key;
					rm_d    = req_type;
					state_d = lort_pkg::S_CNT;
				end
			end
			lort_pkg::S_CNT: begin
				rej_d = 1'b0;
				lo_d  = key_q;
				hi_d  = key_q;
				if (rm_q) begin
					if (c_rdata == '0) begin
						rej_d   = 1'b1;
						kcnt_d  = '0;
						state_d = lort_pkg::S_OUT;
					end else begin
						c_we    = 1'b1;
						c_wdata = c_rdata - CB'(1);
						kcnt_d  = c_rdata - CB'(1);
						state_d = (c_rdata == CB'(1)) ? lort_pkg::S_SLREQ : lort_pkg::S_OUT;
					end
				end else begin
					if (c_rdata == lort_pkg::CNT_MAX) begin
						rej_d   = 1'b1;
						kcnt_d  = c_rdata;
						state_d = lort_pkg::S_OUT;
					end else begin
						c_we    = 1'b1;
						c_wdata = c_rdata + CB'(1);
						kcnt_d  = c_rdata + CB'(1);
						state_d = (c_rdata == '0) ? lort_pkg::S_RREQ : lort_pkg::S_OUT;
					end
				end
			end
			lort_pkg::S_RREQ: begin
				c_raddr = key_q + KB'(1);
				p_raddr = key_q + KB'(1);
				state_d = (key_q == lort_pkg::KEY_LAST) ? lort_pkg::S_LREQ : lort_pkg::S_RRSP;
			end
			lort_pkg::S_RRSP: begin
				if (c_rdata != '0) begin
					if (p_rdata < key_q + KB'(1)) begin
						pr = key_q + KB'(1);
					end
					haddr_d = {1'b0, pr} - {1'b0, key_q};
					hinc_d  = 1'b0;
					hret_d  = lort_pkg::S_LREQ;
					hi_d    = pr;
					state_d = lort_pkg::S_HRD;
				end else begin
					state_d = lort_pkg::S_LREQ;
				end
			end
			lort_pkg::S_LREQ: begin
				c_raddr = key_q - KB'(1);
				p_raddr = key_q - KB'(1);
				state_d = (key_q == '0) ? lort_pkg::S_ADDINS : lort_pkg::S_LRSP;
			end
			lort_pkg::S_LRSP: begin
				if (c_rdata != '0) begin
					if (p_rdata > key_q - KB'(1)) begin
						pr = key_q - KB'(1);
					end
					haddr_d = {1'b0, key_q} - {1'b0, pr};
					hinc_d  = 1'b0;
					hret_d  = lort_pkg::S_ADDINS;
					lo_d    = pr;
					state_d = lort_pkg::S_HRD;
				end else begin
					state_d = lort_pkg::S_ADDINS;
				end
			end
			lort_pkg::S_ADDINS: begin
				ilo_d   = lo_q;
				ihi_d   = hi_q;
				iret_d  = lort_pkg::S_FIXREQ;
				state_d = lort_pkg::S_PW1;
			end
			lort_pkg::S_SLREQ: begin
				c_raddr = lo_q - KB'(1);
				state_d = (lo_q == '0) ? lort_pkg::S_SRREQ : lort_pkg::S_SLRSP;
			end
			lort_pkg::S_SLRSP: begin
				if (c_rdata != '0) begin
					lo_d    = lo_q - KB'(1);
					state_d = lort_pkg::S_SLREQ;
				end else begin
					state_d = lort_pkg::S_SRREQ;
				end
			end
			lort_pkg::S_SRREQ: begin
				c_raddr = hi_q + KB'(1);
				state_d = (hi_q == lort_pkg::KEY_LAST) ? lort_pkg::S_SPLIT : lort_pkg::S_SRRSP;
			end
			lort_pkg::S_SRRSP: begin
				if (c_rdata != '0) begin
					hi_d    = hi_q + KB'(1);
					state_d = lort_pkg::S_SRREQ;
				end else begin
					state_d = lort_pkg::S_SPLIT;
				end
			end
			lort_pkg::S_SPLIT: begin
				haddr_d = {1'b0, hi_q} - {1'b0, lo_q} + LB'(1);
				hinc_d  = 1'b0;
				hret_d  = lort_pkg::S_SPL_L;
				state_d = lort_pkg::S_HRD;
			end
			lort_pkg::S_SPL_L: begin
				if (lo_q < key_q) begin
					ilo_d   = lo_q;
					ihi_d   = key_q - KB'(1);
					iret_d  = lort_pkg::S_SPL_R;
					state_d = lort_pkg::S_PW1;
				end else begin
					state_d = lort_pkg::S_SPL_R;
				end
			end
			lort_pkg::S_SPL_R: begin
				if (key_q < hi_q) begin
					ilo_d   = key_q + KB'(1);
					ihi_d   = hi_q;
					iret_d  = lort_pkg::S_FIXREQ;
					state_d = lort_pkg::S_PW1;
				end else begin
					state_d = lort_pkg::S_FIXREQ;
				end
			end
			lort_pkg::S_PW1: begin
				p_we    = 1'b1;
				p_waddr = ilo_q;
				p_wdata = ihi_q;
				state_d = lort_pkg::S_PW2;
			end
			lort_pkg::S_PW2: begin
				p_we    = 1'b1;
				p_waddr = ihi_q;
				p_wdata = ilo_q;
				if (ins_len > longest_q) begin
					longest_d = ins_len;
				end
				haddr_d = ins_len;
				hinc_d  = 1'b1;
				hret_d  = iret_q;
				state_d = lort_pkg::S_HRD;
			end
			lort_pkg::S_HRD: begin
				h_raddr = haddr_q;
				state_d = lort_pkg::S_HWR;
			end
			lort_pkg::S_HWR: begin
				if (hinc_q) begin
					h_we    = 1'b1;
					h_wdata = h_rdata + lort_pkg::HIST_BITS'(1);
				end else if (h_rdata != '0) begin
					h_we    = 1'b1;
					h_wdata = h_rdata - lort_pkg::HIST_BITS'(1);
				end
				state_d = hret_q;
			end
			lort_pkg::S_FIXREQ: begin
				h_raddr = longest_q;
				state_d = (longest_q == '0) ? lort_pkg::S_OUT : lort_pkg::S_FIXRSP;
			end
			lort_pkg::S_FIXRSP: begin
				if (h_rdata == '0) begin
					longest_d = longest_q - LB'(1);
					state_d   = lort_pkg::S_FIXREQ;
				end else begin
					state_d = lort_pkg::S_OUT;
				end
			end
			lort_pkg::S_OUT: begin
				state_d = lort_pkg::S_IDLE;
			end
			default: begin
				state_d = lort_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lort_pkg::S_CLR;
			clr_q     <= '0;
			longest_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			longest_q <= longest_d;
		end
	end

	always_ff @(posedge clk) begin
		hret_q <= hret_d;
		iret_q <= iret_d;
		haddr_q <= haddr_d;
		key_q  <= key_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		ilo_q  <= ilo_d;
		ihi_q  <= ihi_d;
		rm_q   <= rm_d;
		rej_q  <= rej_d;
		hinc_q <= hinc_d;
		kcnt_q <= kcnt_d;
	end

	assign busy        = (state_q != lort_pkg::S_IDLE);
	assign done        = (state_q == lort_pkg::S_OUT);
	assign longest_run = longest_q;
	assign key_count   = kcnt_q;
	assign rejected    = rej_q;

endmodule

// File: dv/longest_occupied_run_tracker_tb.sv
module longest_occupied_run_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [lort_pkg::KEY_BITS-1:0] key;
		logic                          remove;
	} update_t;

	typedef struct {
		logic [lort_pkg::LEN_BITS-1:0]   longest_run;
		logic [lort_pkg::COUNT_BITS-1:0] key_count;
		logic                            rejected;
	} outcome_t;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_DEL = 1'b1;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [lort_pkg::KEY_BITS-1:0]   key;
	logic                            req_type;
	logic                            done;
	logic [lort_pkg::LEN_BITS-1:0]   longest_run;
	logic [lort_pkg::COUNT_BITS-1:0] key_count;
	logic                            rejected;

	longest_occupied_run_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .key(key),
		.req_type(req_type), .done(done), .longest_run(longest_run),
		.key_count(key_count), .rejected(rejected)
	);

	// Predictor state.
	int unsigned occ_count [lort_pkg::KEY_SPACE];
	int unsigned run_hist [lort_pkg::KEY_SPACE+1];
	int unsigned best_len;

	update_t  pending_updates[$];
	outcome_t expected_outcomes[$];
	int       mismatches;
	bit       stim_done;
	bit       hold_for_drain;
	int       burst_left;
	int       gap_left;

	// The bounds of the run containing k, found by scanning the occupied keys.
	function automatic void run_bounds(input int k, output int lo, output int hi);
		lo = k;
		hi = k;
		while (lo > 0 && occ_count[lo-1] != 0) lo--;
		while (hi < lort_pkg::KEY_SPACE - 1 && occ_count[hi+1] != 0) hi++;
	endfunction

	function automatic outcome_t predict_update(input update_t u);
		outcome_t o;
		int unsigned c;
		int lo, hi;
		c = occ_count[u.key];
		o.rejected = 1'b0;
		if (u.remove) begin
			if (c == 0) begin
				o.rejected = 1'b1;
			end else begin
				if (c == 1) begin
					run_bounds(u.key, lo, hi);
					if (run_hist[hi-lo+1] > 0) run_hist[hi-lo+1]--;
					if (lo < u.key) run_hist[u.key-lo]++;
					if (hi > u.key) run_hist[hi-u.key]++;
				end
				occ_count[u.key] = c - 1;
			end
		end else begin
			if (c == (1 << lort_pkg::COUNT_BITS) - 1) begin
				o.rejected = 1'b1;
			end else begin
				if (c == 0) begin
					occ_count[u.key] = 1;
					run_bounds(u.key, lo, hi);
					if (lo < u.key && run_hist[u.key-lo] > 0) run_hist[u.key-lo]--;
					if (hi > u.key && run_hist[hi-u.key] > 0) run_hist[hi-u.key]--;
					run_hist[hi-lo+1]++;
					if (hi - lo + 1 > best_len) best_len = hi - lo + 1;
				end
				occ_count[u.key] = c + 1;
			end
		end
		while (best_len > 0 && run_hist[best_len] == 0) best_len--;
		o.longest_run = lort_pkg::LEN_BITS'(best_len);
		o.key_count = lort_pkg::COUNT_BITS'(occ_count[u.key]);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic void queue_update(input int k, input logic r);
		update_t u;
		u.key = lort_pkg::KEY_BITS'(k);
		u.remove = r;
		pending_updates.insert(pending_updates.size(), u);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("FAILED: results differ");
		$finish;
	end

	// Driver: bursts of beats with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			key <= '0;
			req_type <= REQ_ADD;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_outcomes.insert(expected_outcomes.size(), predict_update(
					'{key: key, remove: req_type}));
			end
			if (start && busy) begin
				// The beat is still waiting.
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_updates.size() == 0 ||
					(hold_for_drain && expected_outcomes.size() != 0)) begin
				start <= 1'b0;
			end else begin
				update_t u;
				u = pending_updates.pop_front();
				start <= 1'b1;
				key <= u.key;
				req_type <= u.remove;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(12, 1);
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 0);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$display("result with nothing outstanding");
				mismatches++;
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (longest_run !== e.longest_run)
					report_mismatch("longest_run", longest_run, e.longest_run);
				if (key_count !== e.key_count)
					report_mismatch("key_count", key_count, e.key_count);
				if (rejected !== e.rejected)
					report_mismatch("rejected", rejected, e.rejected);
			end
		end
	end

	initial begin
		int base, len, k;
		mismatches = 0;
		hold_for_drain = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats: edges of the key space, merges, splits, rejects.
		queue_update(0, REQ_DEL);
		queue_update(0, REQ_ADD);
		queue_update(lort_pkg::KEY_SPACE - 1, REQ_ADD);
		queue_update(2, REQ_ADD);
		queue_update(1, REQ_ADD);
		queue_update(lort_pkg::KEY_SPACE - 2, REQ_ADD);
		queue_update(1, REQ_ADD);
		queue_update(1, REQ_DEL);
		queue_update(1, REQ_DEL);
		queue_update(1, REQ_DEL);
		queue_update(1, REQ_ADD);
		queue_update(0, REQ_DEL);
		queue_update(2, REQ_DEL);
		queue_update(1, REQ_DEL);
		queue_update(lort_pkg::KEY_SPACE - 1, REQ_DEL);
		queue_update(lort_pkg::KEY_SPACE - 2, REQ_DEL);
		queue_update(lort_pkg::KEY_SPACE - 2, REQ_DEL);
		queue_update(682, REQ_ADD);
		queue_update(341, REQ_ADD);
		queue_update(682, REQ_DEL);
		queue_update(341, REQ_DEL);
		while (pending_updates.size() != 0) @(posedge clk);

		// Pause until every outstanding result has arrived.
		hold_for_drain = 1'b1;
		while (start || expected_outcomes.size() != 0) @(posedge clk);
		hold_for_drain = 1'b0;

		// Random part: in local windows, mix adds that grow runs with removes that punch holes and trim them.
		for (int n = 0; n < 400; ) begin
			base = $urandom_range(lort_pkg::KEY_SPACE - 1, 0);
			len = $urandom_range(24, 1);
			for (int j = 0; j < len && n < 400; j++, n++) begin
				k = base + $urandom_range(len, 0);
				if (k > lort_pkg::KEY_SPACE - 1) k = lort_pkg::KEY_SPACE - 1;
				if ($urandom_range(9, 0) < 6) queue_update(k, REQ_ADD);
				else queue_update(k, REQ_DEL);
			end
			if ($urandom_range(3, 0) == 0) begin
				queue_update($urandom_range(lort_pkg::KEY_SPACE - 1, 0), $urandom_range(1, 0));
				n++;
			end
		end

		while (pending_updates.size() != 0 || start) @(posedge clk);
		while (expected_outcomes.size() != 0) @(posedge clk);
		repeat (2500) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
